>>> design/mlk_pkg.sv
package mlk_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned PatW = 6;
  localparam int unsigned LenW = 3;
  localparam int unsigned IdxW = 8;

  localparam logic [IdxW-1:0] RegDotOn    = IdxW'(0);
  localparam logic [IdxW-1:0] RegDashOn   = IdxW'(1);
  localparam logic [IdxW-1:0] RegElemGap  = IdxW'(2);
  localparam logic [IdxW-1:0] RegCharGap  = IdxW'(3);

  localparam logic [DurW-1:0] DotOnRst    = DurW'(200);
  localparam logic [DurW-1:0] DashOnRst   = DurW'(600);
  localparam logic [DurW-1:0] ElemGapRst  = DurW'(100);
  localparam logic [DurW-1:0] CharGapRst  = DurW'(600);

  typedef struct packed {
    logic [DurW-1:0] dot_on;
    logic [DurW-1:0] dash_on;
    logic [DurW-1:0] elem_gap;
    logic [DurW-1:0] char_gap;
  } cfg_t;

  typedef struct packed {
    logic            led_on;
    logic [DurW-1:0] duration_ms;
    logic            bad_char;
    logic            last;
  } pulse_t;

  // first element in the top bit, 1 = dash
  typedef struct packed {
    logic            ok;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } code_t;

  function automatic code_t morse_lookup(input logic [7:0] ch);
    code_t c;
    c = '{ok: 1'b1, len: '0, pat: '0};
    case (ch)
      8'h41: begin c.len = 3'd2; c.pat = 6'b010000; end
      8'h42: begin c.len = 3'd4; c.pat = 6'b100000; end
      8'h43: begin c.len = 3'd4; c.pat = 6'b101000; end
      8'h44: begin c.len = 3'd3; c.pat = 6'b100000; end
      8'h45: begin c.len = 3'd1; c.pat = 6'b000000; end
      8'h46: begin c.len = 3'd4; c.pat = 6'b001000; end
      8'h47: begin c.len = 3'd3; c.pat = 6'b110000; end
      8'h48: begin c.len = 3'd4; c.pat = 6'b000000; end
      8'h49: begin c.len = 3'd2; c.pat = 6'b000000; end
      8'h4A: begin c.len = 3'd4; c.pat = 6'b011100; end
      8'h4B: begin c.len = 3'd3; c.pat = 6'b101000; end
      8'h4C: begin c.len = 3'd4; c.pat = 6'b010000; end
      8'h4D: begin c.len = 3'd2; c.pat = 6'b110000; end
      8'h4E: begin c.len = 3'd2; c.pat = 6'b100000; end
      8'h4F: begin c.len = 3'd3; c.pat = 6'b111000; end
      8'h50: begin c.len = 3'd4; c.pat = 6'b011000; end
      8'h51: begin c.len = 3'd4; c.pat = 6'b110100; end
      8'h52: begin c.len = 3'd3; c.pat = 6'b010000; end
      8'h53: begin c.len = 3'd3; c.pat = 6'b000000; end
      8'h54: begin c.len = 3'd1; c.pat = 6'b100000; end
      8'h55: begin c.len = 3'd3; c.pat = 6'b001000; end
      8'h56: begin c.len = 3'd4; c.pat = 6'b000100; end
      8'h57: begin c.len = 3'd3; c.pat = 6'b011000; end
      8'h58: begin c.len = 3'd4; c.pat = 6'b100100; end
      8'h59: begin c.len = 3'd4; c.pat = 6'b101100; end
      8'h5A: begin c.len = 3'd4; c.pat = 6'b110000; end
      8'h30: begin c.len = 3'd5; c.pat = 6'b111110; end
      8'h31: begin c.len = 3'd5; c.pat = 6'b011110; end
      8'h32: begin c.len = 3'd5; c.pat = 6'b001110; end
      8'h33: begin c.len = 3'd5; c.pat = 6'b000110; end
      8'h34: begin c.len = 3'd5; c.pat = 6'b000010; end
      8'h35: begin c.len = 3'd5; c.pat = 6'b000000; end
      8'h36: begin c.len = 3'd5; c.pat = 6'b100000; end
      8'h37: begin c.len = 3'd5; c.pat = 6'b110000; end
      8'h38: begin c.len = 3'd5; c.pat = 6'b111000; end
      8'h39: begin c.len = 3'd5; c.pat = 6'b111100; end
      8'h2E: begin c.len = 3'd6; c.pat = 6'b010101; end
      8'h2C: begin c.len = 3'd6; c.pat = 6'b110011; end
      8'h3F: begin c.len = 3'd6; c.pat = 6'b001100; end
      8'h3D: begin c.len = 3'd5; c.pat = 6'b100010; end
      default: begin c.ok = 1'b0; end
    endcase
    return c;
  endfunction

endpackage

>>> design/mlk_seq.sv
module mlk_seq
  import mlk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [7:0] req_char_i,
  output logic       emit_valid_o,
  input  logic       emit_ready_i,
  output pulse_t     emit_o
);

  typedef enum logic [1:0] {
    DUR_ZERO = 2'd0,
    DUR_ON   = 2'd1,
    DUR_EGAP = 2'd2,
    DUR_CGAP = 2'd3
  } dur_sel_e;

  typedef enum logic [1:0] {
    COND_NEXT = 2'd0,
    COND_ALWAYS = 2'd1,
    COND_BAD  = 2'd2,
    COND_MORE = 2'd3
  } cond_e;

  localparam int unsigned StepW = 3;
  localparam int unsigned NumSteps = 5;

  localparam logic [StepW-1:0] StepLoad = 3'd0;
  localparam logic [StepW-1:0] StepOn   = 3'd1;
  localparam logic [StepW-1:0] StepGap  = 3'd2;
  localparam logic [StepW-1:0] StepChar = 3'd3;
  localparam logic [StepW-1:0] StepBad  = 3'd4;

  typedef struct packed {
    logic             wait_req;
    logic             emit;
    dur_sel_e         dur;
    logic             led;
    logic             bad;
    logic             last;
    logic             shift;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uc_t;

  localparam uc_t UcRom [NumSteps] = '{
    '{1'b1, 1'b0, DUR_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, COND_BAD,    StepBad},
    '{1'b0, 1'b1, DUR_ON,   1'b1, 1'b0, 1'b0, 1'b0, COND_NEXT,   StepLoad},
    '{1'b0, 1'b1, DUR_EGAP, 1'b0, 1'b0, 1'b0, 1'b1, COND_MORE,   StepOn},
    '{1'b0, 1'b1, DUR_CGAP, 1'b0, 1'b0, 1'b1, 1'b0, COND_ALWAYS, StepLoad},
    '{1'b0, 1'b1, DUR_ZERO, 1'b0, 1'b1, 1'b1, 1'b0, COND_ALWAYS, StepLoad}
  };

  logic [StepW-1:0] upc_q, upc_d;
  logic [PatW-1:0]  pat_q, pat_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  uc_t              uc;
  code_t            code;
  logic             done;
  logic             take;

  assign uc   = (upc_q < StepW'(NumSteps)) ? UcRom[upc_q] : UcRom[StepLoad];
  assign code = morse_lookup(req_char_i);

  assign req_ready_o  = uc.wait_req;
  assign emit_valid_o = uc.emit;
  assign done = uc.wait_req ? req_valid_i : (!uc.emit || emit_ready_i);
  assign take = uc.wait_req && req_valid_i;

  always_comb begin
    emit_o.led_on   = uc.led;
    emit_o.bad_char = uc.bad;
    emit_o.last     = uc.last;
    case (uc.dur)
      DUR_ON:   emit_o.duration_ms = pat_q[PatW-1] ? cfg_i.dash_on : cfg_i.dot_on;
      DUR_EGAP: emit_o.duration_ms = cfg_i.elem_gap;
      DUR_CGAP: emit_o.duration_ms = cfg_i.char_gap;
      default:  emit_o.duration_ms = '0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    pat_d = pat_q;
    cnt_d = cnt_q;
    if (take) begin
      pat_d = code.pat;
      cnt_d = code.len;
    end else if (done && uc.shift) begin
      pat_d = {pat_q[PatW-2:0], 1'b0};
      cnt_d = cnt_q - LenW'(1);
    end
    if (done) begin
      case (uc.cond)
        COND_ALWAYS: upc_d = uc.target;
        COND_BAD:    upc_d = code.ok ? upc_q + StepW'(1) : uc.target;
        COND_MORE:   upc_d = (cnt_q != LenW'(1)) ? uc.target : upc_q + StepW'(1);
        default:     upc_d = upc_q + StepW'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StepLoad;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

`ifndef ASSERT_OFF
  a_elem_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == StepOn || upc_q == StepGap) |-> (cnt_q != '0))
    else $error("element step with no elements left");
  a_bad_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !code.ok) |=> (upc_q == StepBad))
    else $error("unknown character not routed to bad step");
  a_good_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && code.ok) |=> (upc_q == StepOn && cnt_q == $past(code.len)))
    else $error("known character not loaded");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q < StepW'(NumSteps))
    else $error("step counter out of range");
`endif

endmodule

>>> design/morse_led_keyer.sv
// Morse LED keyer.
// Request channel: in_valid_i/in_ready_o with ascii_char_i, one character per request.
// Result channel: out_valid_o/out_ready_i with led_on_o, duration_ms_o, bad_char_o, last_o.
// Each dot or dash gives a lit pulse then an element gap; a character-gap pulse
// (last_o set) closes the character. An unknown code gives one pulse with bad_char_o.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i at once (0 dot, 1 dash,
// 2 element gap, 3 character gap); other indexes are ignored.
// Sequencing: a microcoded step counter runs one step per cycle unless it waits for a
// request or the output stalls. It takes the request in its load step, then emits one
// pulse per step; the first pulse reaches the output once the step counter has left
// its load step and the result register has loaded that pulse.
// The result register is refilled in the cycle it is taken, so a character's pulses
// stream one per cycle while out_ready_i is high; a full untaken register holds the step.
// Reset returns the sequencer to its load step, clears the output valid flag and
// restores default lengths 200, 600, 100 and 600 ms.
module morse_led_keyer
  import mlk_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      ascii_char_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            led_on_o,
  output logic [DurW-1:0] duration_ms_o,
  output logic            bad_char_o,
  output logic            last_o,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [DurW-1:0] cfg_data_i
);

  cfg_t   cfg_q;
  pulse_t emit;
  pulse_t out_q;
  logic   emit_valid;
  logic   emit_ready;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dot_on: DotOnRst, dash_on: DashOnRst,
                 elem_gap: ElemGapRst, char_gap: CharGapRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDotOn:   cfg_q.dot_on   <= cfg_data_i;
        RegDashOn:  cfg_q.dash_on  <= cfg_data_i;
        RegElemGap: cfg_q.elem_gap <= cfg_data_i;
        RegCharGap: cfg_q.char_gap <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlk_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_char_i   (ascii_char_i),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_o       (emit)
  );

  assign emit_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_on_o      = out_q.led_on;
  assign duration_ms_o = out_q.duration_ms;
  assign bad_char_o    = out_q.bad_char;
  assign last_o        = out_q.last;

endmodule
